// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// bsfd_pkg
// Types and constants of the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 10;
	localparam int unsigned KIND_W = 2;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 512;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(512);

	// framing characters
	localparam logic [BYTE_W-1:0] BYTE_OPEN   = 8'h02;
	localparam logic [BYTE_W-1:0] BYTE_CLOSE  = 8'h03;
	localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h10;
	localparam logic [BYTE_W-1:0] ESCAPE_BIT  = 8'h20;

	typedef enum logic [1:0] {
		PHASE_HUNT   = 2'd0,
		PHASE_FRAME  = 2'd1,
		PHASE_ESCAPE = 2'd2
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// File: design/byte_stuffed_frame_decoder.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder
// STX/ETX/DLE deframer: raw line bytes in, payload bytes and end/abort
// markers out.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  in       in   in_valid/in_stall  line_byte
//  out      out  out_valid/out_stall result_kind, payload_byte, frame_length
//  cfg      in   cfg_wr_en          cfg_wr_data (max_payload_len)
//
//  One line byte per cycle sustained while out is not stalled. A request
//  lands in the input register, the parser decodes it from there into the
//  result register, which drives the out channel.
//  Bytes that make no result (hunting, escape prefix) just drain.
//  in_stall rises only while both registers are full and out is stalled.
//  arst_n clears valid flags, parser phase and count, and reloads the limit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module byte_stuffed_frame_decoder #(
	parameter int unsigned MAX_FRAME_BYTES = bsfd_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_wr_en,
	input  wire logic [bsfd_pkg::LEN_W-1:0]   cfg_wr_data,

	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [bsfd_pkg::BYTE_W-1:0]  line_byte,

	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [bsfd_pkg::KIND_W-1:0]  result_kind,
	output      logic [bsfd_pkg::BYTE_W-1:0]  payload_byte,
	output      logic [bsfd_pkg::LEN_W-1:0]   frame_length
);

	// Hard cap on the payload; the count register cannot go above its width.
	localparam int unsigned LenMax = (1 << bsfd_pkg::LEN_W) - 1;
	localparam int unsigned CapInt = (MAX_FRAME_BYTES > LenMax) ? LenMax : MAX_FRAME_BYTES;
	localparam logic [bsfd_pkg::LEN_W-1:0] Cap = bsfd_pkg::LEN_W'(CapInt);
	localparam logic [bsfd_pkg::LEN_W-1:0] LimitRst =
		(bsfd_pkg::MAX_PAYLOAD_RST > Cap) ? Cap : bsfd_pkg::MAX_PAYLOAD_RST;

	// effective limit, min(register, cap), folded in at write time
	logic [bsfd_pkg::LEN_W-1:0] limit_q;

	// input register
	logic                        valid_s1;
	logic [bsfd_pkg::BYTE_W-1:0] byte_s1;

	// parser state
	bsfd_pkg::phase_t            phase_q, phase_nxt;
	logic [bsfd_pkg::LEN_W-1:0]  count_q, count_nxt;

	// result register
	logic                        valid_s2;
	bsfd_pkg::kind_t             kind_s2;
	logic [bsfd_pkg::BYTE_W-1:0] byte_s2;
	logic [bsfd_pkg::LEN_W-1:0]  len_s2;

	// decode of the byte in s1
	logic                        emit;
	bsfd_pkg::kind_t             kind_nxt;
	logic [bsfd_pkg::BYTE_W-1:0] byte_nxt;
	logic [bsfd_pkg::LEN_W-1:0]  len_nxt;
	logic                        over;
	logic [bsfd_pkg::BYTE_W-1:0] data_byte;

	logic                        advance;
	logic                        step;
	logic                        take_in;

	// result slot free (or being emptied this cycle)
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// ---- config register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LimitRst;
		end else if (cfg_wr_en) begin
			limit_q <= (cfg_wr_data > Cap) ? Cap : cfg_wr_data;
		end
	end

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= line_byte;
		end
	end

	// ---- parser state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bsfd_pkg::PHASE_HUNT;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
		end
	end

	// payload byte after an escape has the escape bit cleared
	assign data_byte = (phase_q == bsfd_pkg::PHASE_ESCAPE) ?
		(byte_s1 & ~bsfd_pkg::ESCAPE_BIT) : byte_s1;
	assign over = (count_q >= limit_q);

	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		emit      = 1'b0;
		kind_nxt  = bsfd_pkg::KIND_DATA;
		byte_nxt  = '0;
		len_nxt   = '0;
		unique case (phase_q)
			bsfd_pkg::PHASE_FRAME: begin
				if (byte_s1 == bsfd_pkg::BYTE_CLOSE) begin
					phase_nxt = bsfd_pkg::PHASE_HUNT;
					count_nxt = '0;
					emit      = 1'b1;
					kind_nxt  = bsfd_pkg::KIND_DONE;
					len_nxt   = count_q;
				end else if (byte_s1 == bsfd_pkg::BYTE_OPEN) begin
					// abort and reopen at once
					count_nxt = '0;
					emit      = 1'b1;
					kind_nxt  = bsfd_pkg::KIND_ABORT;
				end else if (byte_s1 == bsfd_pkg::BYTE_ESCAPE) begin
					phase_nxt = bsfd_pkg::PHASE_ESCAPE;
				end else if (over) begin
					phase_nxt = bsfd_pkg::PHASE_HUNT;
					count_nxt = '0;
					emit      = 1'b1;
					kind_nxt  = bsfd_pkg::KIND_ABORT;
				end else begin
					count_nxt = count_q + 1'b1;
					emit      = 1'b1;
					byte_nxt  = data_byte;
				end
			end
			bsfd_pkg::PHASE_ESCAPE: begin
				if (byte_s1 == bsfd_pkg::BYTE_OPEN) begin
					phase_nxt = bsfd_pkg::PHASE_FRAME;
					count_nxt = '0;
					emit      = 1'b1;
					kind_nxt  = bsfd_pkg::KIND_ABORT;
				end else if ((byte_s1 & bsfd_pkg::ESCAPE_BIT) == '0 || over) begin
					// bad escape or limit hit
					phase_nxt = bsfd_pkg::PHASE_HUNT;
					count_nxt = '0;
					emit      = 1'b1;
					kind_nxt  = bsfd_pkg::KIND_ABORT;
				end else begin
					phase_nxt = bsfd_pkg::PHASE_FRAME;
					count_nxt = count_q + 1'b1;
					emit      = 1'b1;
					byte_nxt  = data_byte;
				end
			end
			default: begin
				// hunting; unused code behaves the same
				if (byte_s1 == bsfd_pkg::BYTE_OPEN) begin
					phase_nxt = bsfd_pkg::PHASE_FRAME;
					count_nxt = '0;
				end else begin
					phase_nxt = bsfd_pkg::PHASE_HUNT;
				end
			end
		endcase
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_s2 <= kind_nxt;
			byte_s2 <= byte_nxt;
			len_s2  <= len_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign result_kind  = kind_s2;
	assign payload_byte = byte_s2;
	assign frame_length = len_s2;

	// ---- assertions ----
	`ASSERT_CLK(a_hunt_count_zero, phase_q == bsfd_pkg::PHASE_HUNT |-> count_q == '0, "count nonzero while hunting")
	`ASSERT_CLK(a_done_to_hunt, step && emit && kind_nxt == bsfd_pkg::KIND_DONE |=> phase_q == bsfd_pkg::PHASE_HUNT, "frame end did not return to hunting")
	`ASSERT_ALWAYS(a_stall_only_full, in_stall |-> valid_s1 && valid_s2 && out_stall, "input stalled with room in the pipe")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame decoder. Raw line bytes go
// in as framed, escaped, broken and noisy streams under several payload
// limits. Every accepted byte runs through a local decoder model. Each
// result from the block is checked in order against that model's output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	// a taken request passes the input register, then the result register
	localparam int DRAIN_CYCLES   = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_COUNT    = 5;
	localparam int PHASE_BYTES    = 420;

	typedef struct packed {
		bsfd_pkg::kind_t             kind;
		logic [bsfd_pkg::BYTE_W-1:0] pbyte;
		logic [bsfd_pkg::LEN_W-1:0]  flen;
	} decoded_t;

	// Decoder model plus the queue of results it still owes.
	class frame_scoreboard_t;
		bsfd_pkg::phase_t           phase;
		logic [bsfd_pkg::LEN_W-1:0] count;
		logic [bsfd_pkg::LEN_W-1:0] limit;
		decoded_t                   expected_q[$];
		int                         errors;

		function new();
			phase  = bsfd_pkg::PHASE_HUNT;
			count  = '0;
			limit  = bsfd_pkg::MAX_PAYLOAD_RST;
			errors = 0;
		endfunction

		function void set_limit(logic [bsfd_pkg::LEN_W-1:0] value);
			limit = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// payload byte, or abort once the effective limit is reached
		function void accept_payload(logic [bsfd_pkg::BYTE_W-1:0] value,
				output decoded_t r);
			logic [bsfd_pkg::LEN_W-1:0] eff;
			eff = (limit > bsfd_pkg::MAX_FRAME_BYTES_DEF) ?
				bsfd_pkg::LEN_W'(bsfd_pkg::MAX_FRAME_BYTES_DEF) : limit;
			r = '{bsfd_pkg::KIND_DATA, '0, '0};
			if (count >= eff) begin
				phase  = bsfd_pkg::PHASE_HUNT;
				count  = '0;
				r.kind = bsfd_pkg::KIND_ABORT;
			end else begin
				count   = count + 1'b1;
				phase   = bsfd_pkg::PHASE_FRAME;
				r.pbyte = value;
			end
		endfunction

		function void note_line_byte(logic [bsfd_pkg::BYTE_W-1:0] raw);
			decoded_t r;
			bit       emits;
			r     = '{bsfd_pkg::KIND_DATA, '0, '0};
			emits = 1'b0;
			case (phase)
				bsfd_pkg::PHASE_FRAME: begin
					if (raw == bsfd_pkg::BYTE_CLOSE) begin
						r.kind = bsfd_pkg::KIND_DONE;
						r.flen = count;
						phase  = bsfd_pkg::PHASE_HUNT;
						count  = '0;
						emits  = 1'b1;
					end else if (raw == bsfd_pkg::BYTE_OPEN) begin
						count  = '0;
						r.kind = bsfd_pkg::KIND_ABORT;
						emits  = 1'b1;
					end else if (raw == bsfd_pkg::BYTE_ESCAPE) begin
						phase = bsfd_pkg::PHASE_ESCAPE;
					end else begin
						accept_payload(raw, r);
						emits = 1'b1;
					end
				end
				bsfd_pkg::PHASE_ESCAPE: begin
					emits = 1'b1;
					if (raw == bsfd_pkg::BYTE_OPEN) begin
						phase  = bsfd_pkg::PHASE_FRAME;
						count  = '0;
						r.kind = bsfd_pkg::KIND_ABORT;
					end else if ((raw & bsfd_pkg::ESCAPE_BIT) != '0) begin
						accept_payload(raw & ~bsfd_pkg::ESCAPE_BIT, r);
					end else begin
						phase  = bsfd_pkg::PHASE_HUNT;
						count  = '0;
						r.kind = bsfd_pkg::KIND_ABORT;
					end
				end
				default: begin
					if (raw == bsfd_pkg::BYTE_OPEN) begin
						phase = bsfd_pkg::PHASE_FRAME;
						count = '0;
					end else begin
						phase = bsfd_pkg::PHASE_HUNT;
					end
				end
			endcase
			if (emits)
				expected_q.push_back(r);
		endfunction

		function void check_result(logic [bsfd_pkg::KIND_W-1:0] kind,
				logic [bsfd_pkg::BYTE_W-1:0] pbyte, logic [bsfd_pkg::LEN_W-1:0] flen);
			decoded_t r;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d byte %0d length %0d", kind, pbyte, flen);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (kind !== r.kind) begin
				$error("result_kind: expected %0d, got %0d", r.kind, kind);
				errors++;
			end
			if (pbyte !== r.pbyte) begin
				$error("payload_byte: expected %0d, got %0d", r.pbyte, pbyte);
				errors++;
			end
			if (flen !== r.flen) begin
				$error("frame_length: expected %0d, got %0d", r.flen, flen);
				errors++;
			end
		endfunction

		function void check_drained();
			if (expected_q.size() != 0) begin
				$error("%0d results never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_wr_en    = 1'b0;
	logic [bsfd_pkg::LEN_W-1:0]    cfg_wr_data  = '0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic [bsfd_pkg::BYTE_W-1:0]   line_byte    = '0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic [bsfd_pkg::KIND_W-1:0]   result_kind;
	logic [bsfd_pkg::BYTE_W-1:0]   payload_byte;
	logic [bsfd_pkg::LEN_W-1:0]    frame_length;

	frame_scoreboard_t sb = new();

	bit hold_request = 1'b0;   // asks the receiver for one long hold-off
	bit tx_burst     = 1'b0;   // sender offers back to back while set
	int quiet_cycles = 0;
	int sent_bytes   = 0;

	// Directed streams; first under the reset limit, then under a limit of one.
	localparam logic [bsfd_pkg::BYTE_W-1:0] DIRECTED_A [21] = '{
		8'h55, bsfd_pkg::BYTE_CLOSE,                            // noise while hunting
		bsfd_pkg::BYTE_OPEN, bsfd_pkg::BYTE_CLOSE,              // empty frame
		bsfd_pkg::BYTE_OPEN, 8'h00, 8'hFF,                      // byte extremes
		bsfd_pkg::BYTE_ESCAPE,                                  // escaped framing chars
		bsfd_pkg::BYTE_OPEN | bsfd_pkg::ESCAPE_BIT,
		bsfd_pkg::BYTE_ESCAPE, bsfd_pkg::BYTE_CLOSE | bsfd_pkg::ESCAPE_BIT,
		bsfd_pkg::BYTE_CLOSE,
		bsfd_pkg::BYTE_OPEN, 8'h41,                             // start inside a frame
		bsfd_pkg::BYTE_OPEN, bsfd_pkg::BYTE_CLOSE,
		bsfd_pkg::BYTE_OPEN, bsfd_pkg::BYTE_ESCAPE,             // start after escape
		bsfd_pkg::BYTE_OPEN,
		bsfd_pkg::BYTE_ESCAPE, bsfd_pkg::BYTE_CLOSE             // bad escape: close char
	};
	localparam logic [bsfd_pkg::BYTE_W-1:0] DIRECTED_B [6] = '{
		bsfd_pkg::BYTE_OPEN, 8'h7E, bsfd_pkg::BYTE_CLOSE,       // fits exactly
		bsfd_pkg::BYTE_OPEN, 8'h11, 8'h22                       // one over the limit
	};

	byte_stuffed_frame_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_byte    (line_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.frame_length (frame_length)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One request on the input channel. Returns at the edge that takes it,
	// with in_valid still high so a back-to-back request needs no toggle.
	task automatic send_line_byte(input logic [bsfd_pkg::BYTE_W-1:0] raw);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		line_byte <= raw;
		do @(posedge clk); while (in_stall);
		sb.note_line_byte(raw);
		sent_bytes++;
	endtask

	// framing chars are always escaped, other bytes now and then
	task automatic send_payload(input logic [bsfd_pkg::BYTE_W-1:0] value);
		if (value == bsfd_pkg::BYTE_OPEN || value == bsfd_pkg::BYTE_CLOSE ||
				value == bsfd_pkg::BYTE_ESCAPE || $urandom_range(0, 7) == 0) begin
			send_line_byte(bsfd_pkg::BYTE_ESCAPE);
			send_line_byte(value | bsfd_pkg::ESCAPE_BIT);
		end else begin
			send_line_byte(value);
		end
	endtask

	task automatic send_frame(input int len);
		send_line_byte(bsfd_pkg::BYTE_OPEN);
		repeat (len) send_payload(bsfd_pkg::BYTE_W'($urandom_range(0, 255)));
		send_line_byte(bsfd_pkg::BYTE_CLOSE);
	endtask

	// Opened frame cut short by one of the framing errors.
	task automatic send_broken_frame();
		send_line_byte(bsfd_pkg::BYTE_OPEN);
		repeat ($urandom_range(0, 6)) send_payload(bsfd_pkg::BYTE_W'($urandom_range(0, 255)));
		case ($urandom_range(0, 3))
			0: send_line_byte(bsfd_pkg::BYTE_OPEN);
			1: begin
				send_line_byte(bsfd_pkg::BYTE_ESCAPE);
				send_line_byte(bsfd_pkg::BYTE_W'($urandom_range(0, 255)) &
					~bsfd_pkg::ESCAPE_BIT);
			end
			2: begin
				send_line_byte(bsfd_pkg::BYTE_ESCAPE);
				send_line_byte(bsfd_pkg::BYTE_OPEN);
			end
			default: begin
				send_line_byte(bsfd_pkg::BYTE_ESCAPE);
				send_line_byte(bsfd_pkg::BYTE_CLOSE);
			end
		endcase
	endtask

	// Stop offering, wait for every owed result, then let the pipe empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_payload_limit(input logic [bsfd_pkg::LEN_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.set_limit(value);
	endtask

	// Receiver: random stall stretches, plus one long hold-off on request.
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Result checker and watchdog on the same edge. Values read here are the
	// ones that stood before the edge, since all drivers use NBAs.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(result_kind, payload_byte, frame_length);
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [bsfd_pkg::LEN_W-1:0] lim;
		int                         eff;
		int                         start;
		int                         len;
		bit                         long_done;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limit of 512, then a limit of one
		tx_burst = 1'b1;
		foreach (DIRECTED_A[i]) send_line_byte(DIRECTED_A[i]);
		drain();
		write_payload_limit(bsfd_pkg::LEN_W'(1));
		foreach (DIRECTED_B[i]) send_line_byte(DIRECTED_B[i]);

		long_done = 1'b0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: lim = bsfd_pkg::LEN_W'(512);
				1: lim = bsfd_pkg::LEN_W'(1);
				2: lim = bsfd_pkg::LEN_W'($urandom_range(2, 24));
				3: lim = bsfd_pkg::LEN_W'($urandom_range(1, 512));
				default: lim = bsfd_pkg::LEN_W'($urandom_range(8, 64));
			endcase
			drain();
			write_payload_limit(lim);
			eff = (lim > bsfd_pkg::MAX_FRAME_BYTES_DEF) ? bsfd_pkg::MAX_FRAME_BYTES_DEF : lim;
			// back-pressure: the block fills while the receiver holds off
			if (p == 0)
				hold_request = 1'b1;
			start = sent_bytes;
			while (sent_bytes - start < PHASE_BYTES) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 9))
					0: begin
						// noise, mostly between frames
						repeat ($urandom_range(1, 4))
							send_line_byte(bsfd_pkg::BYTE_W'($urandom_range(0, 255)));
					end
					1: send_broken_frame();
					2: begin
						// unescaped raw bytes inside a frame
						send_line_byte(bsfd_pkg::BYTE_OPEN);
						repeat ($urandom_range(1, 8))
							send_line_byte(bsfd_pkg::BYTE_W'($urandom_range(0, 255)));
					end
					default: begin
						if (eff == bsfd_pkg::MAX_FRAME_BYTES_DEF && !long_done) begin
							// one frame around the hard maximum
							long_done = 1'b1;
							len = $urandom_range(eff - 2, eff + 2);
						end else if (eff <= 64 && $urandom_range(0, 3) == 0) begin
							len = $urandom_range(eff - 1, eff + 1);
						end else begin
							len = $urandom_range(0, 12);
						end
						send_frame(len);
					end
				endcase
			end
		end

		drain();
		sb.check_drained();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/bsfd_pkg.sv
design/byte_stuffed_frame_decoder.sv
bench/tb_top.sv
